// File: hdl/ihb_pkg.sv
`timescale 1ns / 1ps

package ihb_pkg;

  // sample and arithmetic widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PRESUM_W  = SAMPLE_W + 1;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 15;

  // delay line: delays 3..61 are the only ones the taps reach
  localparam int HIST_DEPTH = 64;
  localparam int TAP_COUNT  = HIST_DEPTH - 2;

  // fifteen symmetric pairs plus the centre tap as a sixteenth lane
  localparam int PAIR_COUNT   = 15;
  localparam int LANE_COUNT   = PAIR_COUNT + 1;
  localparam int CENTRE_LANE  = PAIR_COUNT;
  localparam int CENTRE_DELAY = 32;
  localparam int GROUP_SIZE   = 4;
  localparam int GROUP_COUNT  = LANE_COUNT / GROUP_SIZE;

  // channel order: in-phase then quadrature
  localparam int CH_COUNT = 2;
  localparam int CH_I     = 0;
  localparam int CH_Q     = 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PRESUM_W-1:0] presum_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // per-stage load strobes shared by lanes and sum trees
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

  // lane k multiplies the pair at delays 61-2k and 3+2k; last lane is the centre
  localparam coef_t LANE_COEF [LANE_COUNT] = '{
    16'sd1, -16'sd6, 16'sd16, -16'sd32, 16'sd60, -16'sd102, 16'sd164, -16'sd254,
    16'sd381, -16'sd561, 16'sd818, -16'sd1209, 16'sd1876, -16'sd3347, 16'sd10387,
    16'sd16384
  };

endpackage

// File: hdl/ihb_pair_lane.sv
`timescale 1ns / 1ps

module ihb_pair_lane (
  input  logic              clk,
  input  ihb_pkg::pipe_ld_t ld,
  input  ihb_pkg::sample_t  tap_a,
  input  ihb_pkg::sample_t  tap_b,
  input  ihb_pkg::coef_t    coef,
  output ihb_pkg::acc_t     prod
);
  import ihb_pkg::*;

  presum_t presum_r;
  presum_t presum_nxt;
  acc_t    prod_r;
  acc_t    prod_nxt;
  logic signed [PRESUM_W+COEF_W-1:0] mult_full;

  // pre-add the two symmetric samples
  assign presum_nxt = presum_t'(tap_a) + presum_t'(tap_b);

  // product magnitude stays below 2^30, so the low word holds it exactly
  assign mult_full = presum_r * coef;
  assign prod_nxt  = mult_full[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      presum_r <= presum_nxt;
    end
    if (ld.ld2) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// File: hdl/ihb_sum_tree.sv
`timescale 1ns / 1ps

module ihb_sum_tree (
  input  logic              clk,
  input  ihb_pkg::pipe_ld_t ld,
  input  ihb_pkg::acc_t     prod [ihb_pkg::LANE_COUNT],
  output ihb_pkg::sample_t  result
);
  import ihb_pkg::*;

  acc_t    group_r   [GROUP_COUNT];
  acc_t    group_nxt [GROUP_COUNT];
  acc_t    total;
  sample_t result_r;

  // first level: add lane products in groups of four
  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        group_nxt[g] = group_nxt[g] + prod[g*GROUP_SIZE + j];
      end
    end
  end

  // second level: add the group sums
  always_comb begin
    total = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      total = total + group_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      group_r <= group_nxt;
    end
    // floor shift by the fraction bits, keep the low word (wraps)
    if (ld.ld4) begin
      result_r <= total[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    end
  end

  assign result = result_r;

endmodule

// File: hdl/iq_half_band_fir.sv
`timescale 1ns / 1ps

// Complex half-band FIR, 59 taps, one filtered I/Q pair out for every I/Q pair in.
// Throughput is one sample per clock while out_stall is low. There are four
// register stages (pre-add, multiply, group sum, final sum and scale), and out_valid
// is the valid flag of the last of them. Each channel
// runs sixteen multiplier lanes in parallel (fifteen symmetric pairs and the centre
// tap) followed by a two-level adder tree. The result is the 32-bit sum shifted
// arithmetically right by 15 and truncated to 16 bits, so it wraps rather than
// saturates. The delay lines clear to zero at reset. in_stall only rises when every
// pipeline stage holds data and the output is stalled.
module iq_half_band_fir (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ihb_pkg::sample_t in_i,
  input  ihb_pkg::sample_t in_q,
  output logic             out_valid,
  input  logic             out_stall,
  output ihb_pkg::sample_t out_i,
  output ihb_pkg::sample_t out_q
);
  import ihb_pkg::*;

  logic     s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic     rdy1, rdy2, rdy3, rdy4;
  pipe_ld_t ld;
  sample_t  ch_in   [CH_COUNT];
  sample_t  ch_out  [CH_COUNT];
  sample_t  taps_r  [CH_COUNT][TAP_COUNT];

  // stage ready chain: a stage takes data when empty or when it moves on
  assign rdy4 = !s4_valid_r || !out_stall;
  assign rdy3 = !s3_valid_r || rdy4;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;

  assign ld.ld1 = in_valid && rdy1;
  assign ld.ld2 = s1_valid_r && rdy2;
  assign ld.ld3 = s2_valid_r && rdy3;
  assign ld.ld4 = s3_valid_r && rdy4;

  assign in_stall  = !rdy1;
  assign out_valid = s4_valid_r;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
    end
  end

  assign ch_in[CH_I] = in_i;
  assign ch_in[CH_Q] = in_q;

  // per-channel delay line: shifts once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        for (int t = 0; t < TAP_COUNT; t++) begin
          taps_r[c][t] <= '0;
        end
      end
    end else if (ld.ld1) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        taps_r[c][0] <= ch_in[c];
        for (int t = 1; t < TAP_COUNT; t++) begin
          taps_r[c][t] <= taps_r[c][t-1];
        end
      end
    end
  end

  // lanes read the line before the shift: delay d of the new sample is tap d-1
  for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
    acc_t prod [LANE_COUNT];

    for (genvar k = 0; k < PAIR_COUNT; k++) begin : g_pair
      ihb_pair_lane u_lane (
        .clk   (clk),
        .ld    (ld),
        .tap_a (taps_r[c][TAP_COUNT - 2 - 2*k]),
        .tap_b (taps_r[c][2 + 2*k]),
        .coef  (LANE_COEF[k]),
        .prod  (prod[k])
      );
    end

    ihb_pair_lane u_centre (
      .clk   (clk),
      .ld    (ld),
      .tap_a (taps_r[c][CENTRE_DELAY - 1]),
      .tap_b (sample_t'(0)),
      .coef  (LANE_COEF[CENTRE_LANE]),
      .prod  (prod[CENTRE_LANE])
    );

    ihb_sum_tree u_tree (
      .clk    (clk),
      .ld     (ld),
      .prod   (prod),
      .result (ch_out[c])
    );
  end

  assign out_i = ch_out[CH_I];
  assign out_q = ch_out[CH_Q];

  // input only stalls with the first stage full
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with first stage empty");

  // a free output never backs up the input
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

  // every input transfer lands in the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted sample missing from first stage");

endmodule
